// ----- hdl/fte_pkg.sv -----
// ----------------------------------------------------------------------------
// fte_pkg
// Shared types and constants of the fat-tree route entry generator.
// ----------------------------------------------------------------------------
package fte_pkg;

    localparam int MAX_PORTS_DEF = 64;
    localparam logic [6:0] K_RESET = 7'd4;
    localparam logic [7:0] FIRST_OCTET = 8'd10;

    localparam logic [1:0] OP_EDGE_SFX = 2'd0;
    localparam logic [1:0] OP_AGG_SFX  = 2'd1;
    localparam logic [1:0] OP_AGG_PFX  = 2'd2;
    localparam logic [1:0] OP_CORE_PFX = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_KIND  = 2'd1;
    localparam logic [1:0] ST_BAD_ENTRY = 2'd2;

    typedef struct packed {
        logic        vld;
        logic [1:0]  op;
        logic [5:0]  j;
        logic [16:0] node;
        logic        low_f;
        logic        core_f;
        logic [16:0] rem;
        logic [5:0]  q;
        logic [9:0]  crem;
        logic [4:0]  cq;
        logic [9:0]  cidx;
    } div_stage_t;

    typedef struct packed {
        logic        vld;
        logic [1:0]  op;
        logic [5:0]  j;
        logic [1:0]  status;
        logic [5:0]  pod;
        logic [5:0]  idx;
        logic [9:0]  cidx;
        logic [4:0]  cq;
        logic [16:0] off;
        logic [5:0]  modv;
        logic [11:0] row_p;
        logic [10:0] ah;
        logic [16:0] jp;
    } mid_stage_t;

    function automatic div_stage_t div_step(
        input div_stage_t  s,
        input logic [10:0] per_pod,
        input logic [5:0]  half,
        input logic [2:0]  qb,
        input logic [2:0]  cb,
        input logic        cen
    );
        logic [17:0] dv;
        logic [10:0] ch;
        div_stage_t  r;
        r  = s;
        dv = {7'd0, per_pod} << qb;
        ch = {5'd0, half} << cb;
        if ({1'b0, s.rem} >= dv) begin
            r.rem   = s.rem - dv[16:0];
            r.q[qb] = 1'b1;
        end
        if (cen && ({1'b0, s.crem} >= ch)) begin
            r.crem   = s.crem - ch[9:0];
            r.cq[cb] = 1'b1;
        end
        return r;
    endfunction

endpackage

// ----- hdl/fat_tree_route_entry_generator_unit.sv -----
// ----------------------------------------------------------------------------
// fat_tree_route_entry_generator_unit
// Computes one entry of a k-ary fat-tree two-level routing table per request.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: s_tuser carries the opcode, s_tdata the node id and entry
//   number. m_ channel: m_tuser carries the status, m_tdata the table row,
//   match fields and next hop. Status other than ok zeroes all of m_tdata.
//   cfg_wen/cfg_wdata write the port count k (low bit ignored, clamped to
//   4..MAX_PORTS).
// Throughput: one request per cycle unless stalled or settling; the stages
//   are an input register, a three-stage restoring divider (node by pod
//   size, core index by k/2, two pod quotient bits per stage), a classify
//   stage, a multiply stage and the output register.
// After a configuration write s_tready stays low while the derived sizes
//   (hosts per pod, pod size, first core id) settle.
// Reset: k returns to 4, the pipeline empties.
// Stall: when m_tready is low with a result held, the whole pipeline holds
//   and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module fat_tree_route_entry_generator_unit #(
    parameter int MAX_PORTS = fte_pkg::MAX_PORTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [6:0]  cfg_wdata,   // port_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // node_id[16:0], entry_number[22:17], zero pad
    input  logic [1:0]  s_tuser,     // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,     // table_row[11:0], first_octet[19:12],
                                     // match_pod[25:20], match_low[31:26],
                                     // next_hop[48:32], zero pad
    output logic [1:0]  m_tuser      // status
);
    import fte_pkg::*;

    localparam logic [6:0] K_MAX = 7'(MAX_PORTS);

    logic [6:0]  k_reg;
    logic [5:0]  h;
    logic [10:0] hosts_reg;
    logic [10:0] per_pod_reg;
    logic [16:0] core_base_reg;
    logic [1:0]  settle_reg;
    logic [6:0]  k_next;

    assign h = k_reg[6:1];

    always_comb begin
        k_next = cfg_wdata & 7'h7E;
        if (k_next < 7'd4) begin
            k_next = 7'd4;
        end
        if (k_next > K_MAX) begin
            k_next = K_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg         <= K_RESET;
            hosts_reg     <= 11'd4;
            per_pod_reg   <= 11'd8;
            core_base_reg <= 17'd32;
            settle_reg    <= 2'd0;
        end else begin
            if (cfg_wen) begin
                k_reg      <= k_next;
                settle_reg <= 2'd3;
            end else if (settle_reg != 2'd0) begin
                settle_reg <= settle_reg - 2'd1;
            end
            hosts_reg     <= 11'(h * h);
            per_pod_reg   <= 11'(h * h) + {4'd0, k_reg};
            core_base_reg <= 17'(k_reg * per_pod_reg);
        end
    end

    logic en;
    logic m_tvalid_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en && (settle_reg == 2'd0);

    div_stage_t s1_reg, s2_reg, s3_reg, s4_reg;
    div_stage_t s1_next, s2_next, s3_next, s4_next;
    mid_stage_t s5_reg, s5_next, s6_reg, s6_next;

    always_comb begin
        s1_next        = '0;
        s1_next.vld    = s_tvalid && s_tready;
        s1_next.op     = s_tuser;
        s1_next.node   = s_tdata[16:0];
        s1_next.j      = s_tdata[22:17];
        s1_next.low_f  = s_tdata[16:0] < core_base_reg;
        s1_next.core_f = !s1_next.low_f &&
                         ({1'b0, s_tdata[16:0]} < ({1'b0, core_base_reg} + {7'd0, hosts_reg}));
        s1_next.rem    = s_tdata[16:0];
        s1_next.cidx   = 10'(s_tdata[16:0] - core_base_reg);
        s1_next.crem   = s1_next.cidx;
    end

    always_comb begin
        s2_next = div_step(div_step(s1_reg, per_pod_reg, h, 3'd5, 3'd4, 1'b1),
                           per_pod_reg, h, 3'd4, 3'd3, 1'b1);
        s3_next = div_step(div_step(s2_reg, per_pod_reg, h, 3'd3, 3'd2, 1'b1),
                           per_pod_reg, h, 3'd2, 3'd1, 1'b1);
        s4_next = div_step(div_step(s3_reg, per_pod_reg, h, 3'd1, 3'd0, 1'b1),
                           per_pod_reg, h, 3'd0, 3'd0, 1'b0);
    end

    logic [10:0] pos;
    logic        is_edge, is_agg, bad_kind, bad_entry;
    logic [6:0]  msum;

    always_comb begin
        pos       = s4_reg.rem[10:0];
        is_edge   = s4_reg.low_f && (pos >= hosts_reg) && (pos < hosts_reg + {5'd0, h});
        is_agg    = s4_reg.low_f && (pos >= hosts_reg + {5'd0, h});
        bad_kind  = ((s4_reg.op == OP_EDGE_SFX) && !is_edge) ||
                    (((s4_reg.op == OP_AGG_SFX) || (s4_reg.op == OP_AGG_PFX)) && !is_agg) ||
                    ((s4_reg.op == OP_CORE_PFX) && !s4_reg.core_f);
        bad_entry = (s4_reg.op == OP_CORE_PFX) ? ({1'b0, s4_reg.j} >= k_reg)
                                               : (s4_reg.j >= h);
        s5_next       = '0;
        s5_next.vld   = s4_reg.vld;
        s5_next.op    = s4_reg.op;
        s5_next.j     = s4_reg.j;
        s5_next.pod   = s4_reg.q;
        s5_next.cidx  = s4_reg.cidx;
        s5_next.cq    = s4_reg.cq;
        s5_next.off   = s4_reg.node - s4_reg.rem;
        s5_next.idx   = is_edge ? 6'(pos - hosts_reg) : 6'(pos - hosts_reg - {5'd0, h});
        s5_next.status = bad_kind ? ST_BAD_KIND : (bad_entry ? ST_BAD_ENTRY : ST_OK);
        msum          = {1'b0, s5_next.idx} + {1'b0, s4_reg.j};
        s5_next.modv  = (msum >= {1'b0, h}) ? 6'(msum - {1'b0, h}) : msum[5:0];
    end

    always_comb begin
        s6_next       = s5_reg;
        s6_next.row_p = 12'(s5_reg.pod * h);
        s6_next.ah    = 11'(s5_reg.idx * h);
        s6_next.jp    = 17'(s5_reg.j * per_pod_reg);
    end

    logic [11:0] row;
    logic [7:0]  octet;
    logic [5:0]  mpod, mlow;
    logic [16:0] hop;

    always_comb begin
        row   = '0;
        octet = '0;
        mpod  = '0;
        mlow  = '0;
        hop   = '0;
        if (s6_reg.status == ST_OK) begin
            case (s6_reg.op)
                OP_EDGE_SFX: begin
                    row  = s6_reg.row_p + {6'd0, s6_reg.idx};
                    mlow = s6_reg.j + 6'd2;
                    hop  = s6_reg.off + {6'd0, hosts_reg} + {11'd0, h} + {11'd0, s6_reg.modv};
                end
                OP_AGG_SFX: begin
                    row  = {hosts_reg[10:0], 1'b0} + s6_reg.row_p + {6'd0, s6_reg.idx};
                    mlow = s6_reg.j + 6'd2;
                    hop  = core_base_reg + {6'd0, s6_reg.ah} + {11'd0, s6_reg.modv};
                end
                OP_AGG_PFX: begin
                    row   = s6_reg.row_p + {6'd0, s6_reg.idx};
                    octet = FIRST_OCTET;
                    mpod  = s6_reg.pod;
                    mlow  = s6_reg.j;
                    hop   = s6_reg.off + {6'd0, hosts_reg} + {11'd0, s6_reg.j};
                end
                default: begin
                    row   = {2'd0, s6_reg.cidx};
                    octet = FIRST_OCTET;
                    mpod  = s6_reg.j;
                    hop   = s6_reg.jp + {6'd0, hosts_reg} + {11'd0, h} + {12'd0, s6_reg.cq};
                end
            endcase
        end
    end

    logic [55:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.vld   <= 1'b0;
            s2_reg.vld   <= 1'b0;
            s3_reg.vld   <= 1'b0;
            s4_reg.vld   <= 1'b0;
            s5_reg.vld   <= 1'b0;
            s6_reg.vld   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            s1_reg       <= s1_next;
            s2_reg       <= s2_next;
            s3_reg       <= s3_next;
            s4_reg       <= s4_next;
            s5_reg       <= s5_next;
            s6_reg       <= s6_next;
            m_tvalid_reg <= s6_reg.vld;
            m_tdata_reg  <= {7'd0, hop, mlow, mpod, octet, row};
            m_tuser_reg  <= s6_reg.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wen |=> !s_tready)
        else $error("input taken during configuration settle");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == '0))
        else $error("error result carries nonzero fields");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser != 2'd3))
        else $error("undefined status code");

endmodule

// ----- verif/fat_tree_route_entry_generator_unit_tb.sv -----
// ----------------------------------------------------------------------------
// fat_tree_route_entry_generator_unit_tb
// Drives route entry requests over several port counts with random idling on
// both channels, predicts each table entry and checks every result transfer.
// ----------------------------------------------------------------------------
module fat_tree_route_entry_generator_unit_tb;
    import fte_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  op;
        logic [16:0] node;
        logic [5:0]  entry;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] row;
        logic [7:0]  octet;
        logic [5:0]  mpod;
        logic [5:0]  mlow;
        logic [16:0] hop;
    } route_entry_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    request_t     pending_requests[$];
    route_entry_t expected_entries[$];
    logic [6:0]   port_count_reg = K_RESET;
    int           errors = 0;
    int           cycle_count = 0;
    bit           quiet = 1'b0;
    bit           hold_sink = 1'b0;
    int           src_gap = 0;
    int           sink_gap = 0;

    fat_tree_route_entry_generator_unit dut (.*);

    always #5 aclk = ~aclk;

    function automatic int unsigned eff_ports(logic [6:0] pc);
        int unsigned k;
        k = 32'(pc & 7'h7E);
        if (k < 4) k = 4;
        if (k > MAX_PORTS_DEF) k = MAX_PORTS_DEF;
        return k;
    endfunction

    function automatic route_entry_t route_entry(request_t rq, logic [6:0] pc);
        int unsigned k, h, hosts, per_pod, core_base, pod, pos, idx, off, j;
        bit edge_n, agg_n, core_n;
        route_entry_t r;
        k = eff_ports(pc); h = k / 2; hosts = k * k / 4;
        per_pod = hosts + k; core_base = k * per_pod;
        j = 32'(rq.entry); r = '0;
        edge_n = 1'b0; agg_n = 1'b0; core_n = 1'b0; pod = 0; idx = 0; off = 0;
        if (rq.node < core_base) begin
            pod = rq.node / per_pod; pos = rq.node % per_pod; off = pod * per_pod;
            if (pos >= hosts && pos < hosts + h) begin
                edge_n = 1'b1; idx = pos - hosts;
            end else if (pos >= hosts + h) begin
                agg_n = 1'b1; idx = pos - hosts - h;
            end
        end else if (rq.node < core_base + hosts) begin
            core_n = 1'b1; idx = rq.node - core_base;
        end
        if ((rq.op == OP_EDGE_SFX && !edge_n) ||
            ((rq.op == OP_AGG_SFX || rq.op == OP_AGG_PFX) && !agg_n) ||
            (rq.op == OP_CORE_PFX && !core_n)) begin
            r.status = ST_BAD_KIND;
        end else if ((rq.op == OP_CORE_PFX && j >= k) || (rq.op != OP_CORE_PFX && j >= h)) begin
            r.status = ST_BAD_ENTRY;
        end else begin
            r.status = ST_OK;
            case (rq.op)
                OP_EDGE_SFX: begin
                    r.row = 12'(pod * h + idx); r.mlow = 6'(j + 2);
                    r.hop = 17'(off + hosts + h + (idx + j) % h);
                end
                OP_AGG_SFX: begin
                    r.row = 12'(k * h + pod * h + idx); r.mlow = 6'(j + 2);
                    r.hop = 17'(core_base + idx * h + (idx + j) % h);
                end
                OP_AGG_PFX: begin
                    r.row = 12'(pod * h + idx); r.octet = FIRST_OCTET;
                    r.mpod = 6'(pod); r.mlow = 6'(j); r.hop = 17'(off + hosts + j);
                end
                default: begin
                    r.row = 12'(idx); r.octet = FIRST_OCTET; r.mpod = 6'(j);
                    r.hop = 17'(j * per_pod + hosts + h + idx / h);
                end
            endcase
        end
        return r;
    endfunction

    // Random request biased toward well-formed switch ids and entries.
    function automatic request_t pick_request(logic [6:0] pc);
        int unsigned k, h, hosts, per_pod;
        request_t rq;
        k = eff_ports(pc); h = k / 2; hosts = k * k / 4; per_pod = hosts + k;
        rq.op = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 9) < 8) begin
            case (rq.op)
                OP_EDGE_SFX: rq.node = 17'($urandom_range(0, k - 1) * per_pod + hosts +
                                           $urandom_range(0, h - 1));
                OP_CORE_PFX: rq.node = 17'(k * per_pod + $urandom_range(0, hosts - 1));
                default:     rq.node = 17'($urandom_range(0, k - 1) * per_pod + hosts + h +
                                           $urandom_range(0, h - 1));
            endcase
            rq.entry = 6'($urandom_range(0, (rq.op == OP_CORE_PFX) ? k - 1 : h - 1));
            if ($urandom_range(0, 9) == 0) rq.entry = 6'($urandom_range(0, 63));
        end else begin
            rq.node = 17'($urandom_range(0, 131071));
            rq.entry = 6'($urandom_range(0, 63));
        end
        return rq;
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_entries.push_back(route_entry(pending_requests.pop_front(),
                                                       port_count_reg));
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    src_gap <= $urandom_range(1, 14);
                    s_tvalid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tuser <= pending_requests[0].op;
                    s_tdata <= {1'b0, pending_requests[0].entry, pending_requests[0].node};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge aclk) begin
        route_entry_t exp_e, got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[11:0], m_tdata[19:12], m_tdata[25:20],
                       m_tdata[31:26], m_tdata[48:32]};
                if (expected_entries.size() == 0) begin
                    $error("unexpected result transfer");
                    errors = errors + 1;
                end else begin
                    exp_e = expected_entries.pop_front();
                    if (got.status !== exp_e.status) begin
                        $error("status exp %0d got %0d", exp_e.status, got.status);
                        errors = errors + 1;
                    end
                    if (got.row !== exp_e.row) begin
                        $error("table_row exp %0d got %0d", exp_e.row, got.row);
                        errors = errors + 1;
                    end
                    if (got.octet !== exp_e.octet) begin
                        $error("first_octet exp %0d got %0d", exp_e.octet, got.octet);
                        errors = errors + 1;
                    end
                    if (got.mpod !== exp_e.mpod) begin
                        $error("match_pod exp %0d got %0d", exp_e.mpod, got.mpod);
                        errors = errors + 1;
                    end
                    if (got.mlow !== exp_e.mlow) begin
                        $error("match_low exp %0d got %0d", exp_e.mlow, got.mlow);
                        errors = errors + 1;
                    end
                    if (got.hop !== exp_e.hop) begin
                        $error("next_hop exp %0d got %0d", exp_e.hop, got.hop);
                        errors = errors + 1;
                    end
                end
            end
            if (hold_sink) begin
                m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                sink_gap <= $urandom_range(1, 14);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic drain();
        while (pending_requests.size() != 0 || s_tvalid || expected_entries.size() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic set_ports(logic [6:0] pc);
        @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_wdata <= pc;
        port_count_reg <= pc;
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    task automatic add_request(logic [1:0] op, logic [16:0] node, logic [5:0] entry);
        request_t rq;
        rq.op = op; rq.node = node; rq.entry = entry;
        pending_requests.push_back(rq);
    endtask

    initial begin
        logic [6:0] settings[7];
        int unsigned k, hosts, per_pod;
        settings = '{7'd4, 7'd127, 7'd0, 7'd9, 7'd64, 7'd17, 7'd32};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed at k = 4: every opcode, wrong kinds, entry out of range, extremes
        add_request(OP_EDGE_SFX, 17'd4, 6'd0);
        add_request(OP_EDGE_SFX, 17'd5, 6'd1);
        add_request(OP_EDGE_SFX, 17'd5, 6'd2);
        add_request(OP_EDGE_SFX, 17'd0, 6'd0);
        add_request(OP_AGG_SFX, 17'd6, 6'd0);
        add_request(OP_AGG_SFX, 17'd31, 6'd1);
        add_request(OP_AGG_SFX, 17'd4, 6'd0);
        add_request(OP_AGG_PFX, 17'd7, 6'd1);
        add_request(OP_AGG_PFX, 17'd7, 6'd63);
        add_request(OP_CORE_PFX, 17'd32, 6'd0);
        add_request(OP_CORE_PFX, 17'd35, 6'd3);
        add_request(OP_CORE_PFX, 17'd35, 6'd4);
        add_request(OP_CORE_PFX, 17'd36, 6'd0);
        add_request(OP_CORE_PFX, 17'h1FFFF, 6'd63);
        add_request(OP_EDGE_SFX, 17'h1FFFF, 6'd0);
        drain();

        foreach (settings[s]) begin
            set_ports(settings[s]);
            k = eff_ports(settings[s]); hosts = k * k / 4; per_pod = hosts + k;
            add_request(OP_AGG_SFX, 17'(k * per_pod - 1), 6'(k / 2 - 1));
            add_request(OP_CORE_PFX, 17'(k * per_pod + hosts - 1), 6'(k - 1));
            for (int i = 0; i < 150; i++)
                pending_requests.push_back(pick_request(settings[s]));
            if (s == 2) begin
                hold_sink = 1'b1;
                repeat (300) @(posedge aclk);
                hold_sink = 1'b0;
            end
            if (s == 6) quiet = 1'b1;
            drain();
        end

        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/fte_pkg.sv
hdl/fat_tree_route_entry_generator_unit.sv
verif/fat_tree_route_entry_generator_unit_tb.sv
